@@ rtl/core/hsbg_pkg.sv @@
// ---------------------------------------------------------------------------
// hsbg_pkg
// Shared types, constants and the perceptual brightness curve for the
// hue/saturation/brightness to RGB converter.
// ---------------------------------------------------------------------------
package hsbg_pkg;

   typedef logic [7:0] level_type;
   typedef logic [8:0] hue_type;
   typedef logic [5:0] offset_type;

   localparam hue_type        HUE_MAX     = 9'd359;
   localparam int unsigned    SECTOR_SPAN = 60;
   localparam int unsigned    FLOOR_SHIFT = 8;

   // floor(x / 60) == (x * RECIP_60) >> RECIP_SHIFT for x below 2**16
   localparam int unsigned    RECIP_SHIFT = 22;
   localparam logic [16:0]    RECIP_60    = 17'd69906;

   typedef enum logic [2:0] {
      SECTOR_RED_TO_YELLOW   = 3'd0,
      SECTOR_YELLOW_TO_GREEN = 3'd1,
      SECTOR_GREEN_TO_CYAN   = 3'd2,
      SECTOR_CYAN_TO_BLUE    = 3'd3,
      SECTOR_BLUE_TO_MAGENTA = 3'd4,
      SECTOR_MAGENTA_TO_RED  = 3'd5
   } sector_type;

   // first hue of a sector
   function automatic hue_type sector_start(sector_type sector);
      hue_type start;
      case (sector)
         SECTOR_RED_TO_YELLOW:   start = 9'd0;
         SECTOR_YELLOW_TO_GREEN: start = 9'd60;
         SECTOR_GREEN_TO_CYAN:   start = 9'd120;
         SECTOR_CYAN_TO_BLUE:    start = 9'd180;
         SECTOR_BLUE_TO_MAGENTA: start = 9'd240;
         default:                start = 9'd300;
      endcase
      return start;
   endfunction

   localparam level_type EYE_CURVE [256] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
      8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,
      8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,
      8'd6,   8'd7,   8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,
      8'd8,   8'd9,   8'd9,   8'd9,   8'd10,  8'd10,  8'd10,  8'd11,
      8'd11,  8'd11,  8'd12,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,
      8'd14,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,  8'd16,  8'd16,
      8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,  8'd20,
      8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd23,  8'd24,  8'd24,
      8'd25,  8'd25,  8'd26,  8'd26,  8'd27,  8'd28,  8'd28,  8'd29,
      8'd29,  8'd30,  8'd31,  8'd31,  8'd32,  8'd33,  8'd33,  8'd34,
      8'd35,  8'd35,  8'd36,  8'd37,  8'd37,  8'd38,  8'd39,  8'd40,
      8'd40,  8'd41,  8'd42,  8'd43,  8'd44,  8'd44,  8'd45,  8'd46,
      8'd47,  8'd48,  8'd49,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,
      8'd54,  8'd55,  8'd56,  8'd57,  8'd58,  8'd59,  8'd60,  8'd61,
      8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,  8'd68,  8'd69,
      8'd70,  8'd71,  8'd72,  8'd73,  8'd75,  8'd76,  8'd77,  8'd78,
      8'd79,  8'd80,  8'd82,  8'd83,  8'd84,  8'd85,  8'd87,  8'd88,
      8'd89,  8'd90,  8'd92,  8'd93,  8'd94,  8'd96,  8'd97,  8'd99,
      8'd100, 8'd101, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd110,
      8'd111, 8'd113, 8'd114, 8'd116, 8'd118, 8'd119, 8'd121, 8'd122,
      8'd124, 8'd125, 8'd127, 8'd129, 8'd130, 8'd132, 8'd134, 8'd135,
      8'd137, 8'd139, 8'd141, 8'd142, 8'd144, 8'd146, 8'd148, 8'd149,
      8'd151, 8'd153, 8'd155, 8'd157, 8'd159, 8'd161, 8'd162, 8'd164,
      8'd166, 8'd168, 8'd170, 8'd172, 8'd174, 8'd176, 8'd178, 8'd180,
      8'd182, 8'd185, 8'd187, 8'd189, 8'd191, 8'd193, 8'd195, 8'd197,
      8'd200, 8'd202, 8'd204, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
      8'd218, 8'd220, 8'd222, 8'd225, 8'd227, 8'd230, 8'd232, 8'd234,
      8'd237, 8'd239, 8'd242, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
   };

endpackage

@@ rtl/core/hsbg_if.sv @@
// ---------------------------------------------------------------------------
// hsbg_req_if / hsbg_rsp_if
// Valid/ready channels carrying one colour in and one RGB triple out.
// ---------------------------------------------------------------------------
interface hsbg_req_if;
   logic                 valid;
   logic                 ready;
   logic [8:0]           hue;
   logic [7:0]           saturation;
   logic [7:0]           brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsbg_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           red;
   logic [7:0]           green;
   logic [7:0]           blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

@@ rtl/core/hsb_to_rgb_gamma.sv @@
// ---------------------------------------------------------------------------
// hsb_to_rgb_gamma
// Converts hue/saturation/brightness to red/green/blue bytes through a
// five-stage pipeline, ending in a perceptual brightness curve lookup.
// ---------------------------------------------------------------------------
//  channel    direction  handshake      payload
//  req_chan   in         valid/ready    hue[8:0] saturation[7:0] brightness[7:0]
//  rsp_chan   out        valid/ready    red[7:0] green[7:0] blue[7:0]
//
//  One transaction per cycle sustained while rsp_chan is ready; rsp_chan.valid
//  rises when the result reaches the output register. Stages: sector and
//  floor multiply, ramp multiplies, reciprocal multiply for the divide by 60,
//  ramp add and channel select, curve lookup into the output register.
//  reset clears only the valid bits. When the output is held, the whole
//  pipeline holds and req_chan.ready drops.
// ---------------------------------------------------------------------------
module hsb_to_rgb_gamma (
   input  logic             clock,
   input  logic             reset,
   hsbg_req_if.sink         req_chan,
   hsbg_rsp_if.source       rsp_chan
);

   logic advance;

   // stage 1: sector, offset, floor level
   logic                   v1_ff;
   hsbg_pkg::sector_type   sector1_ff, sector1_in;
   hsbg_pkg::offset_type   off1_ff, off1_in;
   hsbg_pkg::level_type    lo1_ff, lo1_in;
   hsbg_pkg::level_type    bri1_ff;
   logic                   grey1_ff;
   hsbg_pkg::hue_type      hue_clamped;
   hsbg_pkg::hue_type      hue_off;
   logic [15:0]            floor_prod;

   // stage 2: ramp products
   logic                   v2_ff;
   hsbg_pkg::sector_type   sector2_ff;
   hsbg_pkg::level_type    lo2_ff, bri2_ff;
   logic                   grey2_ff;
   logic [13:0]            up_prod2_ff, up_prod2_in;
   logic [13:0]            down_prod2_ff, down_prod2_in;
   hsbg_pkg::level_type    span;
   logic [6:0]             down_pos;

   // stage 3: reciprocal products
   logic                   v3_ff;
   hsbg_pkg::sector_type   sector3_ff;
   hsbg_pkg::level_type    lo3_ff, bri3_ff;
   logic                   grey3_ff;
   logic [30:0]            up_recip3_ff, up_recip3_in;
   logic [30:0]            down_recip3_ff, down_recip3_in;

   // stage 4: channel levels before the curve
   logic                   v4_ff;
   hsbg_pkg::level_type    red4_ff, red4_in;
   hsbg_pkg::level_type    green4_ff, green4_in;
   hsbg_pkg::level_type    blue4_ff, blue4_in;
   hsbg_pkg::level_type    up_level, down_level;

   // stage 5: output register
   logic                   v5_ff;
   hsbg_pkg::level_type    red5_ff, green5_ff, blue5_ff;

   // hold every stage while a result waits at the output
   assign advance        = !v5_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // ---- stage 1 ----
   always_comb begin
      hue_clamped = (req_chan.hue > hsbg_pkg::HUE_MAX) ? hsbg_pkg::HUE_MAX : req_chan.hue;
      if (hue_clamped >= 9'd300) begin
         sector1_in = hsbg_pkg::SECTOR_MAGENTA_TO_RED;
      end else if (hue_clamped >= 9'd240) begin
         sector1_in = hsbg_pkg::SECTOR_BLUE_TO_MAGENTA;
      end else if (hue_clamped >= 9'd180) begin
         sector1_in = hsbg_pkg::SECTOR_CYAN_TO_BLUE;
      end else if (hue_clamped >= 9'd120) begin
         sector1_in = hsbg_pkg::SECTOR_GREEN_TO_CYAN;
      end else if (hue_clamped >= 9'd60) begin
         sector1_in = hsbg_pkg::SECTOR_YELLOW_TO_GREEN;
      end else begin
         sector1_in = hsbg_pkg::SECTOR_RED_TO_YELLOW;
      end
      hue_off    = hue_clamped - hsbg_pkg::sector_start(sector1_in);
      off1_in    = hue_off[5:0];
      // invert at 8 bits so the floor factor is 255 - saturation
      floor_prod = 16'(8'(~req_chan.saturation)) * 16'(req_chan.brightness);
      lo1_in     = floor_prod[hsbg_pkg::FLOOR_SHIFT +: 8];
   end

   // ---- stage 2 ----
   always_comb begin
      span          = bri1_ff - lo1_ff;
      down_pos      = 7'(hsbg_pkg::SECTOR_SPAN) - 7'(off1_ff);
      up_prod2_in   = 14'(span) * 14'(off1_ff);
      down_prod2_in = 14'(span) * 14'(down_pos);
   end

   // ---- stage 3 ----
   always_comb begin
      up_recip3_in   = 31'(up_prod2_ff) * 31'(hsbg_pkg::RECIP_60);
      down_recip3_in = 31'(down_prod2_ff) * 31'(hsbg_pkg::RECIP_60);
   end

   // ---- stage 4 ----
   always_comb begin
      up_level   = lo3_ff + up_recip3_ff[hsbg_pkg::RECIP_SHIFT +: 8];
      down_level = lo3_ff + down_recip3_ff[hsbg_pkg::RECIP_SHIFT +: 8];
      if (grey3_ff) begin
         red4_in   = bri3_ff;
         green4_in = bri3_ff;
         blue4_in  = bri3_ff;
      end else begin
         case (sector3_ff)
            hsbg_pkg::SECTOR_RED_TO_YELLOW: begin
               red4_in = bri3_ff;    green4_in = up_level;   blue4_in = lo3_ff;
            end
            hsbg_pkg::SECTOR_YELLOW_TO_GREEN: begin
               red4_in = down_level; green4_in = bri3_ff;    blue4_in = lo3_ff;
            end
            hsbg_pkg::SECTOR_GREEN_TO_CYAN: begin
               red4_in = lo3_ff;     green4_in = bri3_ff;    blue4_in = up_level;
            end
            hsbg_pkg::SECTOR_CYAN_TO_BLUE: begin
               red4_in = lo3_ff;     green4_in = down_level; blue4_in = bri3_ff;
            end
            hsbg_pkg::SECTOR_BLUE_TO_MAGENTA: begin
               red4_in = up_level;   green4_in = lo3_ff;     blue4_in = bri3_ff;
            end
            default: begin
               red4_in = bri3_ff;    green4_in = lo3_ff;     blue4_in = down_level;
            end
         endcase
      end
   end

   // ---- valid bits ----
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // ---- payload ----
   always_ff @(posedge clock) begin
      if (advance) begin
         sector1_ff     <= sector1_in;
         off1_ff        <= off1_in;
         lo1_ff         <= lo1_in;
         bri1_ff        <= req_chan.brightness;
         grey1_ff       <= (req_chan.saturation == 8'd0);

         sector2_ff     <= sector1_ff;
         lo2_ff         <= lo1_ff;
         bri2_ff        <= bri1_ff;
         grey2_ff       <= grey1_ff;
         up_prod2_ff    <= up_prod2_in;
         down_prod2_ff  <= down_prod2_in;

         sector3_ff     <= sector2_ff;
         lo3_ff         <= lo2_ff;
         bri3_ff        <= bri2_ff;
         grey3_ff       <= grey2_ff;
         up_recip3_ff   <= up_recip3_in;
         down_recip3_ff <= down_recip3_in;

         red4_ff        <= red4_in;
         green4_ff      <= green4_in;
         blue4_ff       <= blue4_in;

         red5_ff        <= hsbg_pkg::EYE_CURVE[red4_ff];
         green5_ff      <= hsbg_pkg::EYE_CURVE[green4_ff];
         blue5_ff       <= hsbg_pkg::EYE_CURVE[blue4_ff];
      end
   end

   assign rsp_chan.valid = v5_ff;
   assign rsp_chan.red   = red5_ff;
   assign rsp_chan.green = green5_ff;
   assign rsp_chan.blue  = blue5_ff;

endmodule
